// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of i_clk while i_rst_n is high.
`define ILP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge of i_clk, reset included.
`define ILP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/ilp_pkg.sv -----
`timescale 1ns / 1ps

package ilp_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int OUT_BITS    = 64;
    localparam int CHAR_BITS   = 8;
    localparam int DIGIT_BITS  = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = DIGIT_BITS'(16);

    localparam logic [CHAR_BITS-1:0] CH_UNDER = "_";
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = "0";
    localparam logic [CHAR_BITS-1:0] CH_X_LO  = "x";
    localparam logic [CHAR_BITS-1:0] CH_X_UP  = "X";
    localparam logic [CHAR_BITS-1:0] CH_B_LO  = "b";
    localparam logic [CHAR_BITS-1:0] CH_B_UP  = "B";

    typedef logic [CHAR_BITS-1:0]  t_char;
    typedef logic [DIGIT_BITS-1:0] t_digit;
    typedef logic [VALUE_BITS-1:0] t_acc;
    typedef logic [OUT_BITS-1:0]   t_value;

    typedef struct packed {
        t_char  char_code;
        t_digit digit;
        logic   is_under;
        logic   is_zero;
        logic   is_hex_mark;
        logic   is_bin_mark;
        logic   is_last;
    } t_token;

    function automatic t_digit digit_of(t_char c);
        t_digit d;
        d = DIGIT_NONE;
        case (c) inside
            ["0":"9"]: d = DIGIT_BITS'(c - "0");
            ["a":"f"]: d = DIGIT_BITS'(c - "a" + 8'd10);
            ["A":"F"]: d = DIGIT_BITS'(c - "A" + 8'd10);
            default:   d = DIGIT_NONE;
        endcase
        return d;
    endfunction

endpackage

// ----- hdl/ilp_in_if.sv -----
`timescale 1ns / 1ps

interface ilp_in_if;
    import ilp_pkg::*;

    logic  valid;
    logic  ready;
    t_char char_code;
    logic  is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink (input valid, input char_code, input is_last, output ready);
endinterface

// ----- hdl/ilp_out_if.sv -----
`timescale 1ns / 1ps

interface ilp_out_if;
    import ilp_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;
    logic   ok;

    modport source (output valid, output value, output ok, input ready);
    modport sink (input valid, input value, input ok, output ready);
endinterface

// ----- hdl/integer_literal_parser_unit.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Payload              Meaning
// i_in      in   char_code, is_last   one character of a literal, last one marked
// o_out     out  value, ok            parsed value and validity, one per literal
//
// One character is taken per cycle when the queue has room; the last character
// of a literal passes through the queue, and its result is registered at the output.
// Back-end steps, a shift-add and overflow compare on the 68-bit product, run
// one per cycle but for an empty queue or a last character behind a stall.
// Reset is synchronous and active low and clears the queue and the parse state.
// A stalled result holds the output register; characters keep flowing until
// another last character reaches the back end and the two-entry queue fills.

module integer_literal_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilp_in_if.sink     i_in,
    ilp_out_if.source  o_out
);
    import ilp_pkg::*;

    logic    push;
    logic    push_ready;
    t_token  push_token;
    logic    q_valid;
    t_token  q_token;
    logic    pop;

    ilp_front u_front (
        .i_in         (i_in),
        .o_push       (push),
        .o_token      (push_token),
        .i_push_ready (push_ready)
    );

    ilp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_token      (push_token),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_token      (q_token),
        .i_pop        (pop)
    );

    ilp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_token (q_token),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ----- hdl/ilp_front.sv -----
`timescale 1ns / 1ps

module ilp_front (
    ilp_in_if.sink           i_in,
    output logic             o_push,
    output ilp_pkg::t_token  o_token,
    input  logic             i_push_ready
);
    import ilp_pkg::*;

    assign i_in.ready = i_push_ready;
    assign o_push     = i_in.valid;

    always_comb begin
        o_token.char_code   = i_in.char_code;
        o_token.digit       = digit_of(i_in.char_code);
        o_token.is_under    = (i_in.char_code == CH_UNDER);
        o_token.is_zero     = (i_in.char_code == CH_ZERO);
        o_token.is_hex_mark = (i_in.char_code == CH_X_LO) || (i_in.char_code == CH_X_UP);
        o_token.is_bin_mark = (i_in.char_code == CH_B_LO) || (i_in.char_code == CH_B_UP);
        o_token.is_last     = i_in.is_last;
    end

endmodule

// ----- hdl/ilp_queue.sv -----
`timescale 1ns / 1ps

module ilp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ilp_pkg::t_token  i_token,
    output logic             o_push_ready,
    output logic             o_valid,
    output ilp_pkg::t_token  o_token,
    input  logic             i_pop
);
    import ilp_pkg::*;

    t_token               r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic [Q_PTR_W-1:0]   n_wr;
    logic [Q_PTR_W-1:0]   n_rd;
    logic [Q_CNT_W-1:0]   n_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_push_ready = (r_cnt != Q_CNT_W'(QUEUE_DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_token      = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

endmodule

// ----- hdl/ilp_back.sv -----
`timescale 1ns / 1ps

module ilp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ilp_pkg::t_token  i_token,
    output logic             o_pop,
    ilp_out_if.source        o_out
);
    import ilp_pkg::*;

    localparam int PROD_W = VALUE_BITS + 4;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    localparam logic [1:0] PH_DIGITS   = 2'd0;
    localparam logic [1:0] PH_LEADZERO = 2'd1;
    localparam logic [1:0] PH_SUFFIX   = 2'd2;

    localparam logic [4:0] SX_EMPTY = 5'd0;
    localparam logic [4:0] SX_SIGN  = 5'd1;
    localparam logic [4:0] SX_DONE  = 5'd2;
    localparam logic [4:0] SX_ONE   = 5'd3;
    localparam logic [4:0] SX_THREE = 5'd4;
    localparam logic [4:0] SX_SIX   = 5'd5;
    localparam logic [4:0] SX_S     = 5'd6;
    localparam logic [4:0] SX_SI    = 5'd7;
    localparam logic [4:0] SX_SIZ   = 5'd8;
    localparam logic [4:0] SX_DEAD  = 5'd9;

    function automatic logic [4:0] sfx_next(logic [4:0] s, t_char c);
        logic [4:0] n;
        n = SX_DEAD;
        case (s)
            SX_EMPTY: n = ((c == "i") || (c == "u")) ? SX_SIGN : SX_DEAD;
            SX_SIGN: begin
                case (c)
                    "8":     n = SX_DONE;
                    "1":     n = SX_ONE;
                    "3":     n = SX_THREE;
                    "6":     n = SX_SIX;
                    "s":     n = SX_S;
                    default: n = SX_DEAD;
                endcase
            end
            SX_ONE:   n = (c == "6") ? SX_DONE : SX_DEAD;
            SX_THREE: n = (c == "2") ? SX_DONE : SX_DEAD;
            SX_SIX:   n = (c == "4") ? SX_DONE : SX_DEAD;
            SX_S:     n = (c == "i") ? SX_SI : SX_DEAD;
            SX_SI:    n = (c == "z") ? SX_SIZ : SX_DEAD;
            SX_SIZ:   n = (c == "e") ? SX_DONE : SX_DEAD;
            default:  n = SX_DEAD;
        endcase
        return n;
    endfunction

    t_acc        r_acc;
    logic [1:0]  r_radix;
    logic [1:0]  r_pos;
    logic [1:0]  r_phase;
    logic [4:0]  r_sfx;
    logic        r_ovf;
    logic        r_bad;
    logic        r_out_valid;
    t_value      r_out_value;
    logic        r_out_ok;

    t_acc        n_acc;
    logic [1:0]  n_radix;
    logic [1:0]  n_pos;
    logic [1:0]  n_phase;
    logic [4:0]  n_sfx;
    logic        n_ovf;
    logic        n_bad;
    logic        n_out_valid;

    logic [PROD_W-1:0] acc_ext;
    logic [PROD_W-1:0] digit_ext;
    logic [PROD_W-1:0] prod;
    logic              prod_ovf;
    t_digit            radix_val;
    logic              sfx_ok;
    t_value            res_value;
    logic              res_ok;

    assign o_pop = i_valid && (!i_token.is_last || !r_out_valid || o_out.ready);

    assign acc_ext   = PROD_W'(r_acc);
    assign digit_ext = PROD_W'(i_token.digit);

    always_comb begin
        case (r_radix)
            RADIX_HEX: begin
                prod      = (acc_ext << 4) + digit_ext;
                radix_val = DIGIT_BITS'(16);
            end
            RADIX_BIN: begin
                prod      = (acc_ext << 1) + digit_ext;
                radix_val = DIGIT_BITS'(2);
            end
            default: begin
                prod      = (acc_ext << 3) + (acc_ext << 1) + digit_ext;
                radix_val = DIGIT_BITS'(10);
            end
        endcase
    end

    assign prod_ovf = |prod[PROD_W-1:VALUE_BITS];

    always_comb begin
        n_acc     = r_acc;
        n_radix   = r_radix;
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_sfx     = r_sfx;
        n_ovf     = r_ovf;
        n_bad     = r_bad;
        sfx_ok    = 1'b0;
        res_value = '0;
        res_ok    = 1'b0;
        if (o_pop) begin
            n_phase = (r_phase == PH_LEADZERO) ? PH_DIGITS : r_phase;
            if ((r_pos == 2'd1) && (r_phase == PH_LEADZERO) && !i_token.is_last
                    && (i_token.is_hex_mark || i_token.is_bin_mark)) begin
                n_radix = i_token.is_hex_mark ? RADIX_HEX : RADIX_BIN;
            end else if (n_phase == PH_SUFFIX) begin
                n_sfx = sfx_next(r_sfx, i_token.char_code);
            end else if (!i_token.is_under) begin
                if (i_token.digit == DIGIT_NONE) begin
                    n_phase = PH_SUFFIX;
                    n_sfx   = sfx_next(SX_EMPTY, i_token.char_code);
                end else begin
                    if (i_token.digit >= radix_val) begin
                        n_bad = 1'b1;
                    end else if (!r_ovf && !r_bad) begin
                        if (prod_ovf) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = prod[VALUE_BITS-1:0];
                        end
                    end
                    if ((r_pos == 2'd0) && i_token.is_zero) begin
                        n_phase = PH_LEADZERO;
                    end
                end
            end
            if (r_pos != 2'd2) begin
                n_pos = r_pos + 2'd1;
            end

            sfx_ok = (n_sfx == SX_EMPTY) || (n_sfx == SX_DONE);
            if (n_bad || !sfx_ok) begin
                res_value = '0;
                res_ok    = 1'b0;
            end else begin
                res_value = OUT_BITS'(n_acc);
                res_ok    = !n_ovf;
            end

            if (i_token.is_last) begin
                n_acc   = '0;
                n_radix = RADIX_DEC;
                n_pos   = 2'd0;
                n_phase = PH_DIGITS;
                n_sfx   = SX_EMPTY;
                n_ovf   = 1'b0;
                n_bad   = 1'b0;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop && i_token.is_last) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_radix     <= RADIX_DEC;
            r_pos       <= 2'd0;
            r_phase     <= PH_DIGITS;
            r_sfx       <= SX_EMPTY;
            r_ovf       <= 1'b0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_radix     <= n_radix;
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_sfx       <= n_sfx;
            r_ovf       <= n_ovf;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_token.is_last) begin
            r_out_value <= res_value;
            r_out_ok    <= res_ok;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;
    assign o_out.ok    = r_out_ok;

endmodule

// ----- hdl/ilp_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ilp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_in_last,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input ilp_pkg::t_value      i_out_value,
    input logic                 i_out_ok
);
    import ilp_pkg::*;

    logic [2:0] r_pending;
    logic [2:0] n_pending;
    logic       last_in;
    logic       res_out;

    assign last_in = i_in_valid && i_in_ready && i_in_last;
    assign res_out = i_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending;
        if (last_in && !res_out) begin
            n_pending = r_pending + 3'd1;
        end else if (res_out && !last_in) begin
            n_pending = r_pending - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'd0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `ILP_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value) && $stable(i_out_ok), "stalled result changed")
    `ILP_ASSERT(a_out_has_source, i_out_valid |-> r_pending != 3'd0, "result without a finished literal")
    `ILP_ASSERT(a_pending_bound, r_pending <= 3'd3, "more finished literals held than buffer space")
    `ILP_ASSERT_ALWAYS(a_reset_idle, $past(!i_rst_n) |-> !i_out_valid && i_in_ready, "not idle after reset")

endmodule

bind integer_literal_parser_unit ilp_checker u_ilp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.is_last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value),
    .i_out_ok    (o_out.ok)
);
